// File: hw/rtl/lcmv_pkg.sv
// ----------------------------------------------------------------------------
// lcmv_pkg
// Shared types and constants for the LCM-of-a-set block.
// ----------------------------------------------------------------------------
package lcmv_pkg;

    localparam int IN_VALUE_W = 16;
    localparam int MULT_W     = 32;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic                  last;
    } in_item_t;

    typedef struct packed {
        logic [MULT_W-1:0] multiple;
        logic              overflow;
        logic              bad_value;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: hw/rtl/lcmv_unit.sv
// ----------------------------------------------------------------------------
// lcmv_unit
// Iterative unit: binary gcd of (a, b), then shift-subtract division a / gcd.
// One step per cycle; quotient is valid when stat.done pulses.
// ----------------------------------------------------------------------------
module lcmv_unit #(
    parameter int VW = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lcmv_pkg::MULT_W-1:0] a,
    input  logic [VW-1:0]              b,
    output logic [lcmv_pkg::MULT_W-1:0] quot,
    output lcmv_pkg::unit_stat_t       stat
);
    import lcmv_pkg::*;

    localparam int KW = $clog2(VW + 1);
    localparam int CW = $clog2(MULT_W);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_GCD  = 3'b010,
        U_DIV  = 3'b100
    } ustate_t;

    ustate_t           state_reg, state_next;
    logic [MULT_W-1:0] x_reg, x_next;
    logic [VW-1:0]     y_reg, y_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [VW-1:0]     g_reg, g_next;
    logic [VW-1:0]     r_reg, r_next;
    logic [MULT_W-1:0] n_reg, n_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              done_reg, done_next;

    logic [MULT_W-1:0] y_ext;
    logic              x_eq, x_gt;
    logic [VW:0]       rs;
    logic [VW:0]       diff;
    logic              ge;

    assign y_ext = {{(MULT_W-VW){1'b0}}, y_reg};
    assign x_eq  = (x_reg == y_ext);
    assign x_gt  = (x_reg > y_ext);
    assign rs    = {r_reg, n_reg[MULT_W-1]};
    assign diff  = rs - {1'b0, g_reg};
    assign ge    = !diff[VW];

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        r_next     = r_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            U_IDLE: begin
                if (start) begin
                    x_next     = a;
                    y_next     = b;
                    n_next     = a;
                    k_next     = '0;
                    state_next = U_GCD;
                end
            end
            U_GCD: begin
                if (x_eq) begin
                    g_next     = y_reg << k_reg;
                    r_next     = '0;
                    cnt_next   = '1;
                    state_next = U_DIV;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + KW'(1);
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (x_gt) begin
                    x_next = x_reg - y_ext;
                end else begin
                    y_next = y_reg - x_reg[VW-1:0];
                end
            end
            U_DIV: begin
                r_next   = ge ? diff[VW-1:0] : rs[VW-1:0];
                n_next   = {n_reg[MULT_W-2:0], ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        g_reg   <= g_next;
        r_reg   <= r_next;
        n_reg   <= n_next;
        cnt_reg <= cnt_next;
    end

    assign quot      = n_reg;
    assign stat.busy = (state_reg != U_IDLE);
    assign stat.done = done_reg;

endmodule

// File: hw/rtl/lcm_of_value_set.sv
// ----------------------------------------------------------------------------
// lcm_of_value_set
// Running least common multiple of a set of values, one value per transfer,
// result emitted on the transfer marked last.
// ----------------------------------------------------------------------------
// Path, transfer to result: a zero, a one, or a value after overflow goes
//   straight to the final step; any other value passes the gcd unit (binary
//   gcd, then division at one quotient bit per cycle), the multiply step and
//   the final step. One value is in work at a time: s_ready is low while it
//   is in work and while a finished set waits for the previous result to leave.
// Reset: synchronous active low; running multiple = 1, flags cleared, no result.
// ----------------------------------------------------------------------------
module lcm_of_value_set #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lcmv_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lcmv_pkg::out_item_t   m_data
);
    import lcmv_pkg::*;

    localparam int VW = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
    localparam int PW = MULT_W + VW;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [VW-1:0]     v_reg, v_next;
    logic              last_reg, last_next;
    logic [MULT_W-1:0] run_reg, run_next;
    logic              ovf_reg, ovf_next;
    logic              zero_reg, zero_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         out_reg, out_next;

    logic [VW-1:0]     vin;
    logic              s_xfer;
    logic              start;
    logic [MULT_W-1:0] quot;
    unit_stat_t        ustat;
    logic [PW-1:0]     prod;

    assign vin     = s_data.value[VW-1:0];
    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign start   = s_xfer && (vin != '0) && (vin != VW'(1)) && !ovf_reg;
    assign prod    = quot * v_reg;

    lcmv_unit #(
        .VW(VW)
    ) u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .a       (run_reg),
        .b       (vin),
        .quot    (quot),
        .stat    (ustat)
    );

    always_comb begin
        state_next   = state_reg;
        v_next       = v_reg;
        last_next    = last_reg;
        run_next     = run_reg;
        ovf_next     = ovf_reg;
        zero_next    = zero_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    v_next    = vin;
                    last_next = s_data.last;
                    if (vin == '0) begin
                        zero_next = 1'b1;
                    end
                    state_next = start ? ST_CALC : ST_FIN;
                end
            end
            ST_CALC: begin
                if (ustat.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (prod[PW-1:MULT_W] != '0) begin
                    ovf_next = 1'b1;
                    run_next = '1;
                end else begin
                    run_next = prod[MULT_W-1:0];
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    out_next.multiple  = zero_reg ? '0 : run_reg;
                    out_next.overflow  = ovf_reg;
                    out_next.bad_value = zero_reg;
                    m_valid_next       = 1'b1;
                    run_next           = MULT_W'(1);
                    ovf_next           = 1'b0;
                    zero_next          = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            run_reg     <= MULT_W'(1);
            ovf_reg     <= 1'b0;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            run_reg     <= run_next;
            ovf_reg     <= ovf_next;
            zero_reg    <= zero_next;
            m_valid_reg <= m_valid_next;
        end
        v_reg    <= v_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == ST_IDLE) && !ustat.busy)
        else $error("gcd unit started while busy");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg != '0)
        else $error("running multiple reached zero");

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (run_reg == '1))
        else $error("overflow without saturation");

    a_emit_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result emitted outside final step");

    a_done_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        ustat.done |-> (state_reg == ST_CALC))
        else $error("unit finished with no value in work");

endmodule

// File: verif/lcm_of_value_set_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_of_value_set_test
// Self-checking bench for the LCM-of-a-set block: a short table of directed
// sets, then random sets. A local model folds every accepted value into a
// running LCM; a result is checked against it or a fixed table value. Both
// sides idle at random, and the result side holds off once for a long time.
// ----------------------------------------------------------------------------
module lcm_of_value_set_test;
    import lcmv_pkg::*;

    localparam int VALUE_BITS   = 16;
    localparam int RANDOM_ITEMS = 1500;
    localparam int LONG_HOLD    = 2000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        in_item_t  item;
        bit        has_fixed;
        out_item_t fixed;
    } vector_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    logic [MULT_W-1:0] lcm_acc;
    logic              lcm_ovf;
    logic              lcm_zero;

    out_item_t   lcm_pending[$];
    vector_row_t directed_rows[$];
    int          error_count    = 0;
    int          items_sent     = 0;
    int          results_seen   = 0;
    bit          quiet_phase    = 1'b0;
    bit          long_hold_done = 1'b0;

    lcm_of_value_set #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] gcd_of(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        while (b != 32'd0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Folds one value into the running LCM; returns 1 when the set closes.
    function automatic bit fold_value(input in_item_t item, output out_item_t res);
        logic [31:0] v;
        logic [31:0] g;
        logic [63:0] prod;
        v = {16'd0, item.value} & 32'((64'd1 << VALUE_BITS) - 64'd1);
        res = '0;
        if (v == 32'd0) begin
            lcm_zero = 1'b1;
        end else if (!lcm_ovf) begin
            g = gcd_of(lcm_acc, v);
            if (g == 32'd0) g = 32'd1;
            prod = 64'(lcm_acc / g) * 64'(v);
            if (prod > 64'hFFFF_FFFF) begin
                lcm_ovf = 1'b1;
                lcm_acc = 32'hFFFF_FFFF;
            end else begin
                lcm_acc = prod[31:0];
            end
        end
        if (!item.last) return 1'b0;
        res.multiple  = lcm_zero ? 32'd0 : lcm_acc;
        res.overflow  = lcm_ovf;
        res.bad_value = lcm_zero;
        lcm_acc  = 32'd1;
        lcm_ovf  = 1'b0;
        lcm_zero = 1'b0;
        return 1'b1;
    endfunction

    task automatic add_row(input logic [15:0] value, input logic last, input bit has_fixed,
                           input logic [31:0] multiple, input logic ovf, input logic bad);
        vector_row_t row;
        row.item.value     = value;
        row.item.last      = last;
        row.has_fixed      = has_fixed;
        row.fixed.multiple = multiple;
        row.fixed.overflow = ovf;
        row.fixed.bad_value = bad;
        directed_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input in_item_t item, input bit has_fixed,
                             input out_item_t fixed);
        int        gap;
        out_item_t predicted;
        gap = quiet_phase ? 0 : int'($urandom_range(0, 10));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (fold_value(item, predicted))
            lcm_pending.push_back(has_fixed ? fixed : predicted);
        items_sent++;
        quiet_phase = ((items_sent / 120) % 5) == 4;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_value();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 3)  return 16'd0;
        if (kind < 8)  return 16'd1;
        if (kind < 20) return 16'd1 << $urandom_range(0, 15);
        if (kind < 55) return 16'($urandom_range(2, 30));
        if (kind < 75) return 16'($urandom_range(2, 255));
        if (kind < 95) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(65000, 65535));
    endfunction

    initial begin : stimulus
        in_item_t  item;
        out_item_t none;
        int        set_len;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        lcm_acc  = 32'd1;
        lcm_ovf  = 1'b0;
        lcm_zero = 1'b0;
        none     = '0;

        //       value      last  fixed  multiple       ovf   bad
        add_row(16'd1,      1'b1, 1'b1, 32'd1,         1'b0, 1'b0);
        add_row(16'd0,      1'b1, 1'b1, 32'd0,         1'b0, 1'b1);
        add_row(16'd65535,  1'b1, 1'b1, 32'd65535,     1'b0, 1'b0);
        add_row(16'd0,      1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd5,      1'b1, 1'b1, 32'd0,         1'b0, 1'b1);
        add_row(16'd65535,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd65534,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd65533,  1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_row(16'd65535,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd65521,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd65519,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd0,      1'b1, 1'b1, 32'd0,         1'b1, 1'b1);
        add_row(16'd1,      1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd1,      1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd7,      1'b1, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd12,     1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd18,     1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd30,     1'b1, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd65535,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd65534,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd65533,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd3,      1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_row(16'd32768,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd32768,  1'b0, 1'b0, 32'd0,         1'b0, 1'b0);
        add_row(16'd1,      1'b1, 1'b1, 32'd32768,     1'b0, 1'b0);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].has_fixed, directed_rows[i].fixed);

        // random sets, mostly short, now and then long
        while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                                  : $urandom_range(1, 5);
            for (int k = 0; k < set_len; k++) begin
                item.value = pick_value();
                item.last  = (k == set_len - 1);
                send_item(item, 1'b0, none);
            end
        end
        s_valid <= 1'b0;

        while (lcm_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : result_side
        out_item_t got;
        out_item_t want;
        int        stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!long_hold_done && results_seen == 60) begin
                stall = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                stall = quiet_phase ? 0 : int'($urandom_range(0, 10));
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = m_data;
            if (lcm_pending.size() == 0) begin
                $error("result transfer with nothing expected: multiple %0d", got.multiple);
                error_count++;
            end else begin
                want = lcm_pending.pop_front();
                if (got.multiple !== want.multiple) begin
                    $error("multiple: expected %0d, got %0d", want.multiple, got.multiple);
                    error_count++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                    error_count++;
                end
                if (got.bad_value !== want.bad_value) begin
                    $error("bad_value: expected %0b, got %0b", want.bad_value, got.bad_value);
                    error_count++;
                end
            end
            results_seen++;
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
